// ----- sv/bale_pkg.sv -----
// shared types and constants of the bounded array list engine
package bale_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned CMD_W        = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT     = 3'd0,
		CMD_DELETE     = 3'd1,
		CMD_LOCATE     = 3'd2,
		CMD_REMOVE_ALL = 3'd3,
		CMD_REVERSE    = 3'd4,
		CMD_READ       = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_REV_RD,
		ST_REV_WLO,
		ST_REV_WHI,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic walk;
		logic rev_rd;
		logic rev_wlo;
		logic rev_whi;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic go_walk;
		logic go_rev;
		logic walk_done;
		logic rev_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

// ----- sv/bale_cmd_if.sv -----
// request channel of the list engine
interface bale_cmd_if import bale_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink (input valid, input command, input position, input value, output ready);
endinterface

// ----- sv/bale_rsp_if.sv -----
// result channel of the list engine
interface bale_rsp_if import bale_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [DATA_W-1:0] element;
	logic [POS_W-1:0]         found_index;
	logic [POS_W-1:0]         list_length;

	modport source (output valid, output ok, output element, output found_index,
		output list_length, input ready);
	modport sink (input valid, input ok, input element, input found_index,
		input list_length, output ready);
endinterface

// ----- sv/bale_ctrl.sv -----
// controller state machine of the list engine
module bale_ctrl import bale_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				if (stat.go_walk) state_nx = ST_WALK;
				else if (stat.go_rev) state_nx = ST_REV_RD;
				else state_nx = ST_FIN;
			end
			ST_WALK: begin
				if (stat.walk_done) state_nx = ST_FIN;
			end
			ST_REV_RD:  state_nx = ST_REV_WLO;
			ST_REV_WLO: state_nx = ST_REV_WHI;
			ST_REV_WHI: begin
				state_nx = stat.rev_last ? ST_FIN : ST_REV_RD;
			end
			ST_FIN: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		cmd.accept  = (state_q == ST_IDLE) && req_valid;
		cmd.load    = (state_q == ST_LOAD);
		cmd.walk    = (state_q == ST_WALK);
		cmd.rev_rd  = (state_q == ST_REV_RD);
		cmd.rev_wlo = (state_q == ST_REV_WLO);
		cmd.rev_whi = (state_q == ST_REV_WHI);
		cmd.commit  = (state_q == ST_FIN) && stat.out_free;
	end

endmodule

// ----- sv/bale_dp.sv -----
// datapath of the list engine: entry memory, walk pointers and result register
module bale_dp import bale_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	output ctrl_stat_t               stat,
	input  logic [CMD_W-1:0]         command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic                     ok,
	output logic signed [DATA_W-1:0] element,
	output logic [POS_W-1:0]         found_index,
	output logic [POS_W-1:0]         list_length
);

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [DATA_W-1:0] mem [CAPACITY];

	cmd_t              op_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     cnt_q, cnt_nx;
	logic [CW-1:0]     src_q, dst_q, rem_q, proc_q, found_q;
	logic              rv_q, ok_q, rsp_valid_q;
	logic [DATA_W-1:0] rda_q, rdb_q, elem_q;

	logic [XW-1:0]     pos_x, cnt_x, found_x, len_x;
	logic              pos_ok, ins_ok, op_ok, hit, first, rd_en_a;
	logic [CW-1:0]     pos_m1, tail_len, src_init, dst_init, rem_init;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;

	assign pos_x    = XW'(pos_q);
	assign cnt_x    = XW'(cnt_q);
	assign pos_ok   = (pos_x != '0) && (pos_x <= cnt_x);
	assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(CAPACITY));
	assign pos_m1   = CW'(pos_x - XW'(1));
	assign tail_len = CW'(cnt_x + XW'(1) - pos_x);

	// pointers and entry count for the walk of the latched request
	always_comb begin
		op_ok    = 1'b0;
		src_init = '0;
		dst_init = '0;
		rem_init = '0;
		unique case (op_q)
			CMD_INSERT: begin
				op_ok    = ins_ok;
				src_init = cnt_q - CW'(1);
				dst_init = cnt_q;
				rem_init = tail_len;
			end
			CMD_DELETE: begin
				op_ok    = pos_ok;
				src_init = pos_m1;
				dst_init = pos_m1;
				rem_init = tail_len;
			end
			CMD_READ: begin
				op_ok    = pos_ok;
				src_init = pos_m1;
				rem_init = CW'(1);
			end
			CMD_LOCATE, CMD_REMOVE_ALL: begin
				op_ok    = 1'b1;
				rem_init = cnt_q;
			end
			CMD_REVERSE: begin
				op_ok    = 1'b1;
				dst_init = cnt_q - CW'(1);
				rem_init = cnt_q >> 1;
			end
			default: op_ok = 1'b0;
		endcase
		if (!op_ok) rem_init = '0;
	end

	assign stat.go_walk   = (op_q != CMD_REVERSE) && (rem_init != '0);
	assign stat.go_rev    = (op_q == CMD_REVERSE) && (rem_init != '0);
	assign stat.walk_done = (rem_q == '0);
	assign stat.rev_last  = (rem_q == CW'(1));
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	assign hit     = (rda_q == val_q);
	assign first   = (proc_q == '0);
	assign rd_en_a = (cmd.walk && (rem_q != '0)) || cmd.rev_rd;

	// single write port: walk copy, swap halves, or the final insert
	always_comb begin
		we    = 1'b0;
		waddr = dst_q[IW-1:0];
		wdata = rda_q;
		priority if (cmd.walk && rv_q) begin
			unique case (op_q)
				CMD_INSERT:     we = 1'b1;
				CMD_DELETE:     we = !first;
				CMD_REMOVE_ALL: we = !hit;
				default:        we = 1'b0;
			endcase
		end else if (cmd.rev_wlo) begin
			we    = 1'b1;
			waddr = src_q[IW-1:0];
			wdata = rdb_q;
		end else if (cmd.rev_whi) begin
			we = 1'b1;
		end else if (cmd.commit && (op_q == CMD_INSERT) && ok_q) begin
			we    = 1'b1;
			waddr = pos_m1[IW-1:0];
			wdata = val_q;
		end else begin
			we = 1'b0;
		end
	end

	always_comb begin
		cnt_nx = cnt_q;
		if (ok_q) begin
			unique case (op_q)
				CMD_INSERT:     cnt_nx = cnt_q + CW'(1);
				CMD_DELETE:     cnt_nx = cnt_q - CW'(1);
				CMD_REMOVE_ALL: cnt_nx = dst_q;
				default:        cnt_nx = cnt_q;
			endcase
		end
	end

	assign found_x = XW'(found_q);
	assign len_x   = XW'(cnt_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cnt_q       <= cnt_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= cmd_t'(command);
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.load) begin
			ok_q    <= op_ok;
			src_q   <= src_init;
			dst_q   <= dst_init;
			rem_q   <= rem_init;
			rv_q    <= 1'b0;
			proc_q  <= '0;
			found_q <= '0;
			elem_q  <= '0;
		end
		if (cmd.walk) begin
			rv_q <= (rem_q != '0);
			if (rem_q != '0) begin
				rem_q <= rem_q - CW'(1);
				src_q <= (op_q == CMD_INSERT) ? src_q - CW'(1) : src_q + CW'(1);
			end
			if (rv_q) begin
				proc_q <= proc_q + CW'(1);
				unique case (op_q)
					CMD_INSERT: dst_q <= dst_q - CW'(1);
					CMD_DELETE: begin
						if (first) elem_q <= rda_q;
						else dst_q <= dst_q + CW'(1);
					end
					CMD_READ: elem_q <= rda_q;
					CMD_LOCATE: begin
						if (hit && (found_q == '0)) found_q <= proc_q + CW'(1);
					end
					CMD_REMOVE_ALL: begin
						if (!hit) dst_q <= dst_q + CW'(1);
					end
					default: ;
				endcase
			end
		end
		if (cmd.rev_whi) begin
			src_q <= src_q + CW'(1);
			dst_q <= dst_q - CW'(1);
			rem_q <= rem_q - CW'(1);
		end
		if (cmd.commit) begin
			ok          <= ok_q;
			element     <= elem_q;
			found_index <= found_x[POS_W-1:0];
			list_length <= len_x[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_a) rda_q <= mem[src_q[IW-1:0]];
		if (cmd.rev_rd) rdb_q <= mem[dst_q[IW-1:0]];
		if (we) mem[waddr] <= wdata;
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- sv/bounded_array_list_engine.sv -----
// bounded array list engine: top level with controller and datapath
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a memory with one write
// port and two registered read ports, and handles one request at a time, each giving one
// result. Entries are moved one per cycle through the single write port: insert, delete,
// read, locate and remove-all are latched, loaded, walk m entries and then fill the result
// register, where m is the number of entries walked (up to the list length, at most
// CAPACITY); reverse reads both ends of each of the floor(length / 2) pairs and writes
// them back, low end first. Failed and unknown requests walk no entry. A new request is
// taken while the previous result still waits on the result channel; the next result then
// waits in its final state until the previous one has left.
module bounded_array_list_engine import bale_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bale_cmd_if.sink   request,
	bale_rsp_if.source result
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	bale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bale_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.command     (request.command),
		.position    (request.position),
		.value       (request.value),
		.rsp_valid   (result.valid),
		.rsp_ready   (result.ready),
		.ok          (result.ok),
		.element     (result.element),
		.found_index (result.found_index),
		.list_length (result.list_length)
	);

	// a failed request reports no element and no index
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ok) |-> (result.element == '0) && (result.found_index == '0))
		else $error("failed request carries element or index");

	// no result can appear in the cycle right after a request is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !$rose(result.valid))
		else $error("result raised too early after request");

	// ready only drops when a request was taken
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(request.ready) |-> $past(request.valid))
		else $error("ready dropped without a request");

endmodule

// ----- tb/sv/bale_list_tracker.sv -----
// list tracker: follows the request and result channels and checks every result
`timescale 1ns / 100ps
module bale_list_tracker import bale_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bale_cmd_if         request,
	bale_rsp_if         result,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] element;
		logic [POS_W-1:0]         found_index;
		logic [POS_W-1:0]         list_length;
	} list_result_t;

	logic signed [DATA_W-1:0] entries[$];
	list_result_t             owed_results[$];
	int unsigned              error_count;

	initial begin
		error_count = 0;
	end

	// updates the tracked list and returns the result the request should give
	function automatic list_result_t apply_list_request(
		input logic [CMD_W-1:0]         cmd,
		input logic [POS_W-1:0]         pos,
		input logic signed [DATA_W-1:0] val
	);
		list_result_t             r;
		logic signed [DATA_W-1:0] kept[$];
		logic signed [DATA_W-1:0] swap;
		int                       n;
		r = '0;
		n = entries.size();
		case (cmd)
			CMD_INSERT: begin
				if (pos >= 1 && pos <= n + 1 && n < CAPACITY) begin
					entries.insert(pos - 1, val);
					r.ok = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos >= 1 && pos <= n) begin
					r.element = entries[pos - 1];
					entries.delete(pos - 1);
					r.ok = 1'b1;
				end
			end
			CMD_LOCATE: begin
				for (int k = 0; k < n; k++) begin
					if (r.found_index == '0 && entries[k] == val)
						r.found_index = POS_W'(k + 1);
				end
				r.ok = 1'b1;
			end
			CMD_REMOVE_ALL: begin
				for (int k = 0; k < n; k++) begin
					if (entries[k] != val)
						kept.push_back(entries[k]);
				end
				entries = kept;
				r.ok = 1'b1;
			end
			CMD_REVERSE: begin
				for (int k = 0; k < n / 2; k++) begin
					swap = entries[k];
					entries[k] = entries[n - 1 - k];
					entries[n - 1 - k] = swap;
				end
				r.ok = 1'b1;
			end
			CMD_READ: begin
				if (pos >= 1 && pos <= n) begin
					r.element = entries[pos - 1];
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.list_length = POS_W'(entries.size());
		return r;
	endfunction

	task automatic check_field(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			// results leave first: a request taken at this edge cannot have one yet
			if (result.valid && result.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t ns: result with no request waiting, expected none, actual ok=%0d",
						$time, result.ok);
					error_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("ok", want.ok, result.ok);
					check_field("element", want.element, result.element);
					check_field("found_index", want.found_index, result.found_index);
					check_field("list_length", want.list_length, result.list_length);
				end
			end
			if (request.valid && request.ready)
				owed_results.push_back(apply_list_request(request.command, request.position,
					request.value));
		end
		mismatches  <= error_count;
		outstanding <= owed_results.size();
	end

endmodule

// ----- tb/sv/tb_bounded_array_list_engine.sv -----
// top of the list engine testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb_bounded_array_list_engine;
	import bale_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS  = 680;
	localparam int unsigned QUIET_FROM    = 580;

	typedef enum logic [1:0] {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	bit                       calm = 1'b0;
	int unsigned              gap_odds = 1;
	int unsigned              idle_cycles = 0;
	int unsigned              mismatches;
	int unsigned              outstanding;
	mix_mode_t                mode = MODE_GROW;
	logic signed [DATA_W-1:0] value_pool[8];

	bale_cmd_if request();
	bale_rsp_if result();

	bounded_array_list_engine #(.CAPACITY(CAPACITY_DEF)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result)
	);

	bale_list_tracker #(.CAPACITY(CAPACITY_DEF)) tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
		input logic signed [DATA_W-1:0] val);
		request.valid    <= 1'b1;
		request.command  <= cmd;
		request.position <= pos;
		request.value    <= val;
		do @(posedge clk); while (!request.ready);
		if (!calm && gap_odds != 0 && $urandom_range(0, 3 * gap_odds) == 0) begin
			request.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// hold off new requests until every result is back
	task automatic wait_drained();
		request.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 3) != 0)
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	task automatic send_random(input mix_mode_t m);
		int unsigned ins_pct;
		int unsigned del_pct;
		int unsigned roll;
		case (m)
			MODE_GROW:   begin ins_pct = 60; del_pct = 8;  end
			MODE_SHRINK: begin ins_pct = 15; del_pct = 45; end
			default:     begin ins_pct = 35; del_pct = 25; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			send_request(CMD_INSERT, POS_W'($urandom_range(1, 5)), pick_value());
		else if (roll < ins_pct + del_pct)
			send_request(CMD_DELETE, POS_W'($urandom_range(1, 12)), pick_value());
		else if (roll < ins_pct + del_pct + 12)
			send_request(CMD_READ, POS_W'($urandom_range(0, 17)), pick_value());
		else if (roll < ins_pct + del_pct + 20)
			send_request(CMD_LOCATE, POS_W'($urandom()), pick_value());
		else if (roll < ins_pct + del_pct + 25)
			send_request(CMD_REVERSE, POS_W'($urandom()), pick_value());
		else if (roll < ins_pct + del_pct + 30)
			send_request(CMD_REMOVE_ALL, POS_W'($urandom()), pick_value());
		else
			// noise: any code, any position, any value
			send_request(CMD_W'($urandom_range(0, 7)), POS_W'($urandom()), $urandom());
	endtask

	initial begin
		request.valid    = 1'b0;
		request.command  = CMD_INSERT;
		request.position = '0;
		request.value    = '0;
		value_pool[0] = 32'sd0;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sh8000_0000;
		value_pool[3] = 32'sh7fff_ffff;
		for (int k = 4; k < 8; k++)
			value_pool[k] = $urandom();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: failing access, commands that always succeed
		send_request(CMD_READ, 5'd1, 32'sd0);
		send_request(CMD_DELETE, 5'd1, 32'sd0);
		send_request(CMD_LOCATE, 5'd0, 32'sd0);
		send_request(CMD_REVERSE, 5'd0, 32'sd0);
		send_request(CMD_REMOVE_ALL, 5'd0, 32'sd5);
		// insert at position zero and past length + 1
		send_request(CMD_INSERT, 5'd0, 32'sd7);
		send_request(CMD_INSERT, 5'd2, 32'sd7);
		send_request(CMD_INSERT, 5'd1, 32'sh8000_0000);
		send_request(CMD_INSERT, 5'd2, 32'sh7fff_ffff);
		send_request(CMD_INSERT, 5'd1, -32'sd1);
		send_request(CMD_INSERT, 5'd4, 32'sd0);
		send_request(CMD_INSERT, 5'd6, 32'sd9);
		send_request(CMD_REVERSE, 5'd0, 32'sd0);
		send_request(CMD_LOCATE, 5'd0, 32'sh8000_0000);
		send_request(CMD_LOCATE, 5'd0, 32'sd12345);
		send_request(CMD_READ, 5'd1, 32'sd0);
		send_request(CMD_READ, 5'd4, 32'sd0);
		send_request(CMD_READ, 5'd5, 32'sd0);
		send_request(CMD_READ, 5'd31, 32'sd0);
		send_request(CMD_DELETE, 5'd2, 32'sd0);
		send_request(CMD_INSERT, 5'd1, -32'sd1);
		send_request(CMD_REMOVE_ALL, 5'd0, -32'sd1);
		send_request(CMD_REVERSE, 5'd0, 32'sd0);
		send_request(CMD_UNUSED_LO, 5'd1, 32'sd3);
		send_request(CMD_UNUSED_HI, 5'd31, 32'sh7fff_ffff);
		wait_drained();

		// run into a full list
		repeat (18) send_request(CMD_INSERT, POS_W'($urandom_range(1, 3)), pick_value());
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				mode     = mix_mode_t'($urandom_range(0, 2));
				gap_odds = $urandom_range(0, 3);
			end
			if (i == 300)
				wait_drained();
			if (i == QUIET_FROM)
				calm = 1'b1;
			send_random(mode);
		end
		request.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("bounded_array_list_engine verification clean");
		else
			$display("bounded_array_list_engine verification failed");
		$finish;
	end

	// result side back-pressure in bursts, with odds that are redrawn as the tick counter runs
	initial begin
		int unsigned tick;
		int unsigned odds;
		tick = 0;
		odds = 1;
		result.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 64 == 0)
				odds = $urandom_range(0, 3);
			if (!calm && odds != 0 && $urandom_range(0, 4 * odds) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (request.valid && request.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("bounded_array_list_engine verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ----- bounded_array_list_engine.f -----
sv/bale_pkg.sv
sv/bale_cmd_if.sv
sv/bale_rsp_if.sv
sv/bale_ctrl.sv
sv/bale_dp.sv
sv/bounded_array_list_engine.sv
tb/sv/bale_list_tracker.sv
tb/sv/tb_bounded_array_list_engine.sv
